@@ rtl/prtb_pkg.sv @@
package prtb_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT   = 32;

   localparam int OP_BITS      = 3;
   localparam int INDEX_BITS   = 4;
   localparam int RELOAD_BITS  = 32;
   localparam int MASK_BITS    = 16;
   localparam int TICK_BITS    = 32;

   localparam logic [OP_BITS-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_BITS-1:0] OP_ALLOCATE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_CHANGE   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_ENABLE   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_RELEASE  = 3'd4;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_ALLOC_FAIL = 1'b1;

   typedef struct packed {
      logic exec;
   } cmd_type;

endpackage

@@ rtl/prtb_ctrl.sv @@
module prtb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prtb_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_EMPTY = 2'b01,
      ST_FULL  = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign rsp_valid = (state_ff == ST_FULL);
   assign req_ready = (state_ff == ST_EMPTY) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd.exec  = accept;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_EMPTY: begin
            if (accept) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (!accept && rsp_ready) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_EMPTY;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/prtb_dp.sv @@
module prtb_dp #(
   parameter int NUM_CHANNELS = prtb_pkg::NUM_CHANNELS_DEFAULT,
   parameter int COUNT_BITS   = prtb_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  prtb_pkg::cmd_type                  cmd,
   input  logic [prtb_pkg::OP_BITS-1:0]       req_operation,
   input  logic [prtb_pkg::INDEX_BITS-1:0]    req_timer_index,
   input  logic [prtb_pkg::RELOAD_BITS-1:0]   req_reload_count,
   input  logic                               req_enable,
   output logic [prtb_pkg::MASK_BITS-1:0]     rsp_fired_mask,
   output logic [prtb_pkg::INDEX_BITS-1:0]    rsp_assigned_index,
   output logic                               rsp_status,
   output logic [prtb_pkg::TICK_BITS-1:0]     rsp_tick_count
);

   localparam logic [63:0] COUNT_MASK = {64{1'b1}} >> (64 - COUNT_BITS);

   logic [COUNT_BITS-1:0] counter_ff [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] counter_in [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] reload_ff  [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] reload_in  [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] dec        [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] enabled_ff, enabled_in;
   logic [NUM_CHANNELS-1:0] in_use_ff, in_use_in;
   logic [NUM_CHANNELS-1:0] sel;
   logic [NUM_CHANNELS-1:0] fired;
   logic [NUM_CHANNELS+prtb_pkg::MASK_BITS-1:0] fired_wide;
   logic [prtb_pkg::TICK_BITS-1:0]  tick_ff, tick_in;
   logic [prtb_pkg::INDEX_BITS-1:0] assigned;
   logic                            status;
   logic                            found;
   logic                            idx_ok;
   logic [63:0]                     reload_wide;
   logic [63:0]                     reload_sat;
   logic [COUNT_BITS-1:0]           clamped;

   logic [prtb_pkg::MASK_BITS-1:0]  fired_mask_ff;
   logic [prtb_pkg::INDEX_BITS-1:0] assigned_ff;
   logic                            status_ff;

   assign idx_ok      = {3'b000, req_timer_index} < 7'(NUM_CHANNELS);
   assign reload_wide = {32'b0, req_reload_count};
   assign reload_sat  = (reload_wide > COUNT_MASK) ? COUNT_MASK : reload_wide;
   assign clamped     = (reload_sat == 64'd0) ? COUNT_BITS'(1) : reload_sat[COUNT_BITS-1:0];
   assign fired_wide  = {{prtb_pkg::MASK_BITS{1'b0}}, fired};

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         dec[c] = counter_ff[c] - COUNT_BITS'(1);
         sel[c] = ({3'b000, req_timer_index} == 7'(c));
      end
   end

   always_comb begin
      counter_in = counter_ff;
      reload_in  = reload_ff;
      enabled_in = enabled_ff;
      in_use_in  = in_use_ff;
      tick_in    = tick_ff;
      fired      = '0;
      assigned   = '0;
      status     = prtb_pkg::STATUS_OK;
      found      = 1'b0;
      unique case (req_operation)
         prtb_pkg::OP_TICK: begin
            tick_in = tick_ff + 32'd1;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (in_use_ff[c] && enabled_ff[c]) begin
                  if (dec[c] == '0) begin
                     fired[c]      = 1'b1;
                     counter_in[c] = reload_ff[c];
                  end else begin
                     counter_in[c] = dec[c];
                  end
               end
            end
         end
         prtb_pkg::OP_ALLOCATE: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (!found && !in_use_ff[c]) begin
                  found         = 1'b1;
                  reload_in[c]  = clamped;
                  counter_in[c] = clamped;
                  enabled_in[c] = 1'b1;
                  in_use_in[c]  = 1'b1;
                  assigned      = 4'(c);
               end
            end
            status = found ? prtb_pkg::STATUS_OK : prtb_pkg::STATUS_ALLOC_FAIL;
         end
         prtb_pkg::OP_CHANGE: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (idx_ok && sel[c]) begin
                  reload_in[c]  = clamped;
                  counter_in[c] = clamped;
               end
            end
         end
         prtb_pkg::OP_ENABLE: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (idx_ok && sel[c]) begin
                  enabled_in[c] = req_enable;
                  if (req_enable) counter_in[c] = reload_ff[c];
               end
            end
         end
         prtb_pkg::OP_RELEASE: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (idx_ok && sel[c]) in_use_in[c] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // channel state and control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '{default: '0};
         reload_ff  <= '{default: '0};
         enabled_ff <= '0;
         in_use_ff  <= '0;
         tick_ff    <= '0;
      end else if (cmd.exec) begin
         counter_ff <= counter_in;
         reload_ff  <= reload_in;
         enabled_ff <= enabled_in;
         in_use_ff  <= in_use_in;
         tick_ff    <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         fired_mask_ff <= fired_wide[prtb_pkg::MASK_BITS-1:0];
         assigned_ff   <= assigned;
         status_ff     <= status;
      end
   end

   assign rsp_fired_mask     = fired_mask_ff;
   assign rsp_assigned_index = assigned_ff;
   assign rsp_status         = status_ff;
   assign rsp_tick_count     = tick_ff;

endmodule

@@ rtl/periodic_reload_timer_bank.sv @@
// a word accepted on req is registered and appears on rsp in the next cycle
// throughput: one word per cycle while rsp is ready; all channels update in parallel
// the output register frees in the cycle its word is taken, so req stays ready
// reset: all channels free and disabled, tick count zero, no result pending
module periodic_reload_timer_bank #(
   parameter int NUM_CHANNELS = prtb_pkg::NUM_CHANNELS_DEFAULT,
   parameter int COUNT_BITS   = prtb_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [prtb_pkg::OP_BITS-1:0]       req_operation,
   input  logic [prtb_pkg::INDEX_BITS-1:0]    req_timer_index,
   input  logic [prtb_pkg::RELOAD_BITS-1:0]   req_reload_count,
   input  logic                               req_enable,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [prtb_pkg::MASK_BITS-1:0]     rsp_fired_mask,
   output logic [prtb_pkg::INDEX_BITS-1:0]    rsp_assigned_index,
   output logic                               rsp_status,
   output logic [prtb_pkg::TICK_BITS-1:0]     rsp_tick_count
);

   prtb_pkg::cmd_type cmd;

   prtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   prtb_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_operation),
      .req_timer_index    (req_timer_index),
      .req_reload_count   (req_reload_count),
      .req_enable         (req_enable),
      .rsp_fired_mask     (rsp_fired_mask),
      .rsp_assigned_index (rsp_assigned_index),
      .rsp_status         (rsp_status),
      .rsp_tick_count     (rsp_tick_count)
   );

endmodule

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS = prtb_pkg::NUM_CHANNELS_DEFAULT;
   localparam int COUNT_W = prtb_pkg::COUNT_BITS_DEFAULT;
   localparam logic [prtb_pkg::OP_BITS-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [prtb_pkg::OP_BITS-1:0] OP_SPARE_LAST = 3'd7;
   localparam int STALL_LIMIT = 1000;
   localparam int WORDS_PER_PHASE = 500;
   localparam int PRINT_LIMIT = 100;
   localparam logic KNOWN = 1'b1;
   localparam logic PREDICTED = 1'b0;

   typedef struct packed {
      logic [prtb_pkg::MASK_BITS-1:0]  fired;
      logic [prtb_pkg::INDEX_BITS-1:0] index;
      logic                            status;
      logic [prtb_pkg::TICK_BITS-1:0]  ticks;
   } timer_result_type;

   typedef struct packed {
      logic [prtb_pkg::OP_BITS-1:0]     op;
      logic [prtb_pkg::INDEX_BITS-1:0]  index;
      logic [prtb_pkg::RELOAD_BITS-1:0] reload;
      logic                             enable;
      logic                             known;
      timer_result_type                 result;
   } timer_cmd_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [prtb_pkg::OP_BITS-1:0]     req_operation;
   logic [prtb_pkg::INDEX_BITS-1:0]  req_timer_index;
   logic [prtb_pkg::RELOAD_BITS-1:0] req_reload_count;
   logic                             req_enable;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [prtb_pkg::MASK_BITS-1:0]   rsp_fired_mask;
   logic [prtb_pkg::INDEX_BITS-1:0]  rsp_assigned_index;
   logic                             rsp_status;
   logic [prtb_pkg::TICK_BITS-1:0]   rsp_tick_count;

   logic [COUNT_W-1:0]             chan_count [CHANNELS];
   logic [COUNT_W-1:0]             chan_period [CHANNELS];
   logic                           chan_enabled [CHANNELS];
   logic                           chan_in_use [CHANNELS];
   logic [prtb_pkg::TICK_BITS-1:0] tick_total;

   timer_result_type pending_results[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;

   periodic_reload_timer_bank DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_timer_index(req_timer_index),
      .req_reload_count(req_reload_count),
      .req_enable(req_enable),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_fired_mask(rsp_fired_mask),
      .rsp_assigned_index(rsp_assigned_index),
      .rsp_status(rsp_status),
      .rsp_tick_count(rsp_tick_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic timer_result_type apply_timer_op(
         logic [prtb_pkg::OP_BITS-1:0] op,
         logic [prtb_pkg::INDEX_BITS-1:0] index,
         logic [prtb_pkg::RELOAD_BITS-1:0] reload,
         logic enable);
      timer_result_type r;
      logic [COUNT_W-1:0] period;
      logic found;
      int ch;
      r = '0;
      r.status = prtb_pkg::STATUS_OK;
      found = 1'b0;
      ch = int'(index);
      period = (reload == '0) ? COUNT_W'(1) : COUNT_W'(reload);
      case (op)
         prtb_pkg::OP_TICK: begin
            tick_total = tick_total + 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
               if (chan_in_use[c] && chan_enabled[c]) begin
                  chan_count[c] = chan_count[c] - 1'b1;
                  if (chan_count[c] == '0) begin
                     if (c < prtb_pkg::MASK_BITS) r.fired[c] = 1'b1;
                     chan_count[c] = chan_period[c];
                  end
               end
            end
         end
         prtb_pkg::OP_ALLOCATE: begin
            r.status = prtb_pkg::STATUS_ALLOC_FAIL;
            for (int c = 0; c < CHANNELS; c++) begin
               if (!found && !chan_in_use[c]) begin
                  found = 1'b1;
                  chan_period[c] = period;
                  chan_count[c] = period;
                  chan_enabled[c] = 1'b1;
                  chan_in_use[c] = 1'b1;
                  r.index = prtb_pkg::INDEX_BITS'(c);
                  r.status = prtb_pkg::STATUS_OK;
               end
            end
         end
         prtb_pkg::OP_CHANGE: begin
            if (ch < CHANNELS) begin
               chan_period[ch] = period;
               chan_count[ch] = period;
            end
         end
         prtb_pkg::OP_ENABLE: begin
            if (ch < CHANNELS) begin
               chan_enabled[ch] = enable;
               if (enable) chan_count[ch] = chan_period[ch];
            end
         end
         prtb_pkg::OP_RELEASE: begin
            if (ch < CHANNELS) chan_in_use[ch] = 1'b0;
         end
         default: begin
         end
      endcase
      r.ticks = tick_total;
      return r;
   endfunction

   function automatic timer_cmd_type row(logic [prtb_pkg::OP_BITS-1:0] op,
                                         logic [prtb_pkg::INDEX_BITS-1:0] index,
                                         logic [prtb_pkg::RELOAD_BITS-1:0] reload,
                                         logic enable, logic known,
                                         logic [prtb_pkg::MASK_BITS-1:0] fired,
                                         logic [prtb_pkg::INDEX_BITS-1:0] assigned,
                                         logic status,
                                         logic [prtb_pkg::TICK_BITS-1:0] ticks);
      timer_cmd_type cmd;
      cmd.op = op;
      cmd.index = index;
      cmd.reload = reload;
      cmd.enable = enable;
      cmd.known = known;
      cmd.result.fired = fired;
      cmd.result.index = assigned;
      cmd.result.status = status;
      cmd.result.ticks = ticks;
      return cmd;
   endfunction

   function automatic timer_cmd_type random_cmd();
      timer_cmd_type cmd;
      int sel;
      cmd = '0;
      sel = $urandom_range(0, 99);
      if (sel < 55) cmd.op = prtb_pkg::OP_TICK;
      else if (sel < 67) cmd.op = prtb_pkg::OP_ALLOCATE;
      else if (sel < 76) cmd.op = prtb_pkg::OP_CHANGE;
      else if (sel < 88) cmd.op = prtb_pkg::OP_ENABLE;
      else if (sel < 98) cmd.op = prtb_pkg::OP_RELEASE;
      else cmd.op = prtb_pkg::OP_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      cmd.index = prtb_pkg::INDEX_BITS'($urandom_range(0, CHANNELS - 1));
      sel = $urandom_range(0, 99);
      if (sel < 70) cmd.reload = $urandom_range(0, 12);
      else if (sel < 90) cmd.reload = $urandom_range(13, 400);
      else cmd.reload = $urandom;
      cmd.enable = 1'($urandom_range(0, 1));
      cmd.known = PREDICTED;
      return cmd;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic send_word(input timer_cmd_type cmd);
      timer_result_type predicted;
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= cmd.op;
      req_timer_index <= cmd.index;
      req_reload_count <= cmd.reload;
      req_enable <= cmd.enable;
      do @(posedge clock); while (!req_ready);
      predicted = apply_timer_op(cmd.op, cmd.index, cmd.reload, cmd.enable);
      pending_results.push_back(cmd.known ? cmd.result : predicted);
   endtask

   // called only at the edge where a word was just taken
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b1;
      else       rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("word with nothing expected", '0, rsp_tick_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_fired_mask !== want.fired)
               report_mismatch("fired_mask", want.fired, rsp_fired_mask);
            if (rsp_assigned_index !== want.index)
               report_mismatch("assigned_index", want.index, rsp_assigned_index);
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_tick_count !== want.ticks)
               report_mismatch("tick_count", want.ticks, rsp_tick_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      timer_cmd_type directed[$];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= prtb_pkg::OP_TICK;
      req_timer_index <= '0;
      req_reload_count <= '0;
      req_enable <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         chan_count[c] = '0;
         chan_period[c] = '0;
         chan_enabled[c] = 1'b0;
         chan_in_use[c] = 1'b0;
      end
      tick_total = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(row(prtb_pkg::OP_TICK, 4'd0, 32'd0, 1'b0,
                             KNOWN, 16'h0, 4'd0, prtb_pkg::STATUS_OK, 32'd1));
      directed.push_back(row(prtb_pkg::OP_ALLOCATE, 4'd9, 32'd0, 1'b0,
                             KNOWN, 16'h0, 4'd0, prtb_pkg::STATUS_OK, 32'd1));
      directed.push_back(row(prtb_pkg::OP_ALLOCATE, 4'd0, 32'hFFFF_FFFF, 1'b1,
                             KNOWN, 16'h0, 4'd1, prtb_pkg::STATUS_OK, 32'd1));
      directed.push_back(row(prtb_pkg::OP_ALLOCATE, 4'd15, 32'd2, 1'b0,
                             KNOWN, 16'h0, 4'd2, prtb_pkg::STATUS_OK, 32'd1));
      // fill the remaining channels
      for (int c = 3; c < CHANNELS; c++)
         directed.push_back(row(prtb_pkg::OP_ALLOCATE, 4'd0, 32'(c + 1), 1'b0,
                                PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(prtb_pkg::OP_ALLOCATE, 4'd5, 32'd7, 1'b1,
                             KNOWN, 16'h0, 4'd0, prtb_pkg::STATUS_ALLOC_FAIL, 32'd1));
      directed.push_back(row(prtb_pkg::OP_TICK, 4'd0, 32'd0, 1'b0,
                             KNOWN, 16'h1, 4'd0, prtb_pkg::STATUS_OK, 32'd2));
      directed.push_back(row(prtb_pkg::OP_RELEASE, 4'd3, 32'd0, 1'b0,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(prtb_pkg::OP_RELEASE, 4'd3, 32'd0, 1'b0,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(prtb_pkg::OP_CHANGE, 4'd3, 32'd0, 1'b0,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(prtb_pkg::OP_ENABLE, 4'd3, 32'd0, 1'b1,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(prtb_pkg::OP_ENABLE, 4'd2, 32'd0, 1'b0,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(prtb_pkg::OP_TICK, 4'd0, 32'd0, 1'b0,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(prtb_pkg::OP_ENABLE, 4'd2, 32'd0, 1'b1,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(prtb_pkg::OP_CHANGE, 4'd15, 32'hFFFF_FFFF, 1'b0,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      directed.push_back(row(OP_SPARE_FIRST, 4'd15, 32'hFFFF_FFFF, 1'b1,
                             KNOWN, 16'h0, 4'd0, prtb_pkg::STATUS_OK, 32'd3));
      directed.push_back(row(OP_SPARE_LAST, 4'd15, 32'hFFFF_FFFF, 1'b1,
                             KNOWN, 16'h0, 4'd0, prtb_pkg::STATUS_OK, 32'd3));
      directed.push_back(row(prtb_pkg::OP_TICK, 4'd0, 32'd0, 1'b0,
                             PREDICTED, '0, '0, prtb_pkg::STATUS_OK, '0));
      foreach (directed[i]) send_word(directed[i]);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 62; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 62; end
            default: begin sender_idle_pct = 22; rsp_stall_pct = 22; end
         endcase
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_word(random_cmd());
            if (n == WORDS_PER_PHASE / 2 || n == WORDS_PER_PHASE - 1) drain_results();
         end
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
